[hdl/pid_controller_clamped_macros.svh]
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared property wrappers for the concurrent checks of the controller.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/pidc_pkg.sv]
// ----------------------------------------------------------------------------
// PID controller package
// Types, register indexes, sequencer states and saturation helpers shared
// by the controller datapath and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

	// Signed Q16.16 and unsigned Q15.16 values.
	typedef logic signed [31:0] q16_t;
	typedef logic [30:0] uq16_t;

	// Width of the wide accumulator for sums of floored products.
	localparam int ACC_W = 51;
	typedef logic signed [ACC_W-1:0] acc_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
	localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd3;
	localparam logic [2:0] REG_DRIVE_LIMIT   = 3'd4;
	localparam logic [2:0] REG_ACCUM_LIMIT   = 3'd5;

	localparam uq16_t PERIOD_RESET = 31'd65536;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_E,
		ST_INT_ADD,
		ST_INT_CLAMP,
		ST_DIV,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_ACC_D,
		ST_SAT,
		ST_DONE
	} state_t;

	// Divider status towards the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Saturate a wide signed value to the 32 bit signed range.
	function automatic q16_t sat_s32(input acc_t v);
		if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
			return v[31:0];
		end else if (v[ACC_W-1]) begin
			return 32'sh8000_0000;
		end else begin
			return 32'sh7FFF_FFFF;
		end
	endfunction

	// Clamp to plus or minus a magnitude limit; a zero limit leaves the value.
	function automatic q16_t clamp_mag(input q16_t v, input uq16_t lim);
		logic signed [32:0] vx;
		logic signed [32:0] lx;
		logic signed [32:0] nx;
		vx = 33'(v);
		lx = $signed({2'b00, lim});
		nx = -lx;
		if (lim == '0) begin
			return v;
		end else if (vx > lx) begin
			return lx[31:0];
		end else if (vx < nx) begin
			return nx[31:0];
		end else begin
			return v;
		end
	endfunction

endpackage

`default_nettype wire

[hdl/pid_controller_clamped.sv]
// ----------------------------------------------------------------------------
// PID controller, derivative on measurement, clamped integral and output
// Signed Q16.16 controller: one drive word for each setpoint and measured
// word, built by a small sequencer around a shared multiplier and a divider.
// ----------------------------------------------------------------------------
// Usage
// The input channel carries setpoint and measured; a word is taken when
// in_valid is high and in_stall is low. Each input word yields one drive word
// on the output channel, taken when out_valid is high and out_stall is low.
// Gains, sample period and limits are written through cfg_we, cfg_index and
// cfg_data; unknown indexes are ignored. The user must write them only while
// the controller is idle; the block itself does not enforce this. The
// derivative is formed by the bit-serial divider, which yields 49 quotient
// bits; the first word after reset and a zero sample period need no
// division. in_stall falls in the cycle the result is loaded, so a new word
// is taken only once the last one is through. A result waiting behind
// out_stall does not hold back the next input word; only the final load of
// the following result waits for it.
// Reset clears the integral, the previous measurement and the gains and
// limits, and sets the sample period to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pid_controller_clamped_macros.svh"

module pid_controller_clamped (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire pidc_pkg::q16_t  setpoint,
	input  wire pidc_pkg::q16_t  measured,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output pidc_pkg::q16_t       drive,
	input  wire logic            cfg_we,
	input  wire logic [2:0]      cfg_index,
	input  wire logic [31:0]     cfg_data
);

	import pidc_pkg::*;

	state_t state_q;
	state_t state_d;

	// Configuration registers.
	q16_t  prop_gain_q;
	q16_t  integ_gain_q;
	q16_t  deriv_gain_q;
	uq16_t period_q;
	uq16_t drive_lim_q;
	uq16_t accum_lim_q;

	// Controller state.
	q16_t integral_q;
	q16_t last_q;
	logic have_last_q;

	// Working registers of one word.
	q16_t               err_q;
	logic signed [32:0] diff_q;
	logic               div_en_q;
	q16_t               isum_q;
	q16_t               deriv_q;
	acc_t               acc_q;
	q16_t               dsum_q;
	q16_t               drive_q;
	logic               out_valid_q;

	// Sequencer outputs.
	logic signed [31:0] mul_a;
	logic signed [32:0] mul_b;
	logic               div_start;
	logic               load_out;
	logic               accept;

	logic signed [64:0] prod_q;
	logic signed [48:0] prod_sh;
	q16_t               div_quot;
	div_stat_t          div_stat;

	logic signed [32:0] drive_x;
	logic signed [32:0] lim_x;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// Product shifted right by 16 bits: floor of the Q33.32 value in Q33.16.
	assign prod_sh = prod_q[64:16];

	pidc_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	pidc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.diff    (diff_q),
		.divisor (period_q),
		.quot_q  (div_quot),
		.stat    (div_stat)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, multiplier operands and strobes.
	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_MUL_E;
				end
			end
			ST_MUL_E: begin
				mul_a   = err_q;
				mul_b   = $signed({2'b00, period_q});
				state_d = ST_INT_ADD;
			end
			ST_INT_ADD: begin
				state_d = ST_INT_CLAMP;
			end
			ST_INT_CLAMP: begin
				div_start = div_en_q;
				state_d   = div_en_q ? ST_DIV : ST_MUL_P;
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_MUL_P;
				end
			end
			ST_MUL_P: begin
				mul_a   = prop_gain_q;
				mul_b   = 33'(err_q);
				state_d = ST_MUL_I;
			end
			ST_MUL_I: begin
				mul_a   = integ_gain_q;
				mul_b   = 33'(integral_q);
				state_d = ST_MUL_D;
			end
			ST_MUL_D: begin
				mul_a   = deriv_gain_q;
				mul_b   = 33'(deriv_q);
				state_d = ST_ACC_D;
			end
			ST_ACC_D: begin
				state_d = ST_SAT;
			end
			ST_SAT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration and persistent controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= '0;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			period_q     <= PERIOD_RESET;
			drive_lim_q  <= '0;
			accum_lim_q  <= '0;
			integral_q   <= '0;
			last_q       <= '0;
			have_last_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PROP_GAIN:     prop_gain_q  <= cfg_data;
					REG_INTEG_GAIN:    integ_gain_q <= cfg_data;
					REG_DERIV_GAIN:    deriv_gain_q <= cfg_data;
					REG_SAMPLE_PERIOD: period_q     <= cfg_data[30:0];
					REG_DRIVE_LIMIT:   drive_lim_q  <= cfg_data[30:0];
					REG_ACCUM_LIMIT:   accum_lim_q  <= cfg_data[30:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				last_q      <= measured;
				have_last_q <= 1'b1;
			end
			if (state_q == ST_INT_CLAMP) begin
				integral_q <= clamp_mag(isum_q, accum_lim_q);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_stall == 1'b0) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers of the word in progress.
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q    <= sat_s32(ACC_W'(setpoint) - ACC_W'(measured));
			diff_q   <= 33'(last_q) - 33'(measured);
			div_en_q <= have_last_q && (period_q != '0);
			deriv_q  <= '0;
		end
		case (state_q)
			ST_INT_ADD: isum_q  <= sat_s32(ACC_W'(integral_q) + ACC_W'(prod_sh));
			ST_DIV:     deriv_q <= div_quot;
			ST_MUL_I:   acc_q   <= ACC_W'(prod_sh);
			ST_MUL_D:   acc_q   <= acc_q + ACC_W'(prod_sh);
			ST_ACC_D:   acc_q   <= acc_q + ACC_W'(prod_sh);
			ST_SAT:     dsum_q  <= sat_s32(acc_q);
			default: begin
			end
		endcase
		if (load_out) begin
			drive_q <= clamp_mag(dsum_q, drive_lim_q);
		end
	end

	// Widened drive and limit for the range check.
	assign drive_x = 33'(drive_q);
	assign lim_x   = $signed({2'b00, drive_lim_q});

	// A divider result only arrives while the sequencer waits for it.
	`PIDC_ASSERT_NOW(a_div_done_in_wait, div_stat.done, state_q == ST_DIV, "divider done outside wait")
	// A new result only appears from the final sequencer step.
	`PIDC_ASSERT_NOW(a_out_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE, "result without final step")
	// A waiting result respects the drive limit.
	`PIDC_ASSERT_NOW(a_drive_in_limit, out_valid_q && drive_lim_q != '0, (drive_x <= lim_x) && (drive_x >= -lim_x), "drive outside limit")
	// A divider start is taken: the divider then reports busy while the sequencer waits.
	`PIDC_ASSERT_NEXT(a_div_start_idle, div_start, div_stat.busy && state_q == ST_DIV, "divider start lost")

endmodule

`default_nettype wire

[hdl/pidc_mul.sv]
// ----------------------------------------------------------------------------
// PID controller shared multiplier
// One signed 32 by 33 bit multiplier with a registered product, used in turn
// for the integral increment and the three gain products.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_mul (
	input  wire logic               clk,
	input  wire logic signed [31:0] a,
	input  wire logic signed [32:0] b,
	output logic signed [64:0]      prod_q
);

	// Exact product, registered before any further arithmetic.
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

`default_nettype wire

[hdl/pidc_div.sv]
// ----------------------------------------------------------------------------
// PID controller derivative divider
// Restoring divider, one quotient bit per cycle: divides the measurement
// change scaled by 2^16 by the sample period, truncating towards zero and
// saturating the quotient to the 32 bit signed range.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [32:0]   diff,
	input  wire pidc_pkg::uq16_t      divisor,
	output pidc_pkg::q16_t            quot_q,
	output pidc_pkg::div_stat_t       stat
);

	import pidc_pkg::*;

	localparam int NUM_W = 49;
	localparam int CNT_W = 6;

	logic             busy_q;
	logic             fin_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [31:0]      rem_q;
	uq16_t            den_q;

	logic [32:0]      mag;
	logic [31:0]      rem_sh;
	logic [32:0]      trial;
	logic             fits;
	logic [31:0]      neg_quo;

	// Magnitude of the dividend; the most negative difference still fits unsigned.
	assign mag = diff[32] ? 33'(-diff) : 33'(diff);

	// One trial subtraction a cycle.
	assign rem_sh  = {rem_q[30:0], num_q[NUM_W-1]};
	assign trial   = {1'b0, rem_sh} - {2'b00, den_q};
	assign fits    = !trial[32];
	assign neg_quo = -quo_q[31:0];

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift registers of the long division and the signed result.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {mag, 16'h0000};
			quo_q <= '0;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= diff[32];
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? trial[31:0] : rem_sh;
		end
		if (fin_q) begin
			if (!neg_q) begin
				quot_q <= (quo_q[NUM_W-1:31] != '0) ? 32'sh7FFF_FFFF : $signed(quo_q[31:0]);
			end else if (quo_q[NUM_W-1:32] != '0 || (quo_q[31] && quo_q[30:0] != '0)) begin
				quot_q <= 32'sh8000_0000;
			end else begin
				quot_q <= $signed(neg_quo);
			end
		end
	end

	assign stat.busy = busy_q | fin_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire
